/* rtl/core/ftls_pkg.sv */
package ftls_pkg;

   localparam int unsigned CHAR_W   = 8;
   localparam int unsigned LENGTH_W = 8;
   localparam int unsigned PHASE_W  = 4;

   localparam logic [PHASE_W-1:0] PH_START    = 4'd0;
   localparam logic [PHASE_W-1:0] PH_SIGN     = 4'd1;
   localparam logic [PHASE_W-1:0] PH_INT      = 4'd2;
   localparam logic [PHASE_W-1:0] PH_POINT    = 4'd3;
   localparam logic [PHASE_W-1:0] PH_FRAC     = 4'd4;
   localparam logic [PHASE_W-1:0] PH_EXP_E    = 4'd5;
   localparam logic [PHASE_W-1:0] PH_EXP_SIGN = 4'd6;
   localparam logic [PHASE_W-1:0] PH_EXP_DIG  = 4'd7;
   localparam logic [PHASE_W-1:0] PH_DONE     = 4'd8;

   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_EXP   = 8'h65;

   typedef logic [PHASE_W-1:0] phase_type;

   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              is_final;
   } req_word_type;

   typedef struct packed {
      logic                token_valid;
      logic [LENGTH_W-1:0] token_length;
      logic                length_saturated;
   } rsp_word_type;

   typedef struct packed {
      phase_type phase;
      logic      accepting;
   } step_result_type;

endpackage

/* rtl/core/ftls_stream_if.sv */
interface ftls_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/ftls_scan_step.sv */
module ftls_scan_step (
   input  ftls_pkg::phase_type       phase,
   input  logic [ftls_pkg::CHAR_W-1:0] char_code,
   output ftls_pkg::step_result_type result
);

   logic      is_digit;
   logic      is_minus;
   logic      is_point;
   logic      is_exp;
   ftls_pkg::phase_type next_phase;

   always_comb begin
      is_digit = char_code inside {[8'h30:8'h39]};
      is_minus = (char_code == ftls_pkg::CH_MINUS);
      is_point = (char_code == ftls_pkg::CH_POINT);
      is_exp   = (char_code == ftls_pkg::CH_EXP);

      next_phase = ftls_pkg::PH_DONE;
      case (phase)
         ftls_pkg::PH_START: begin
            if (is_minus)      next_phase = ftls_pkg::PH_SIGN;
            else if (is_digit) next_phase = ftls_pkg::PH_INT;
            else if (is_point) next_phase = ftls_pkg::PH_POINT;
         end
         ftls_pkg::PH_SIGN: begin
            if (is_digit)      next_phase = ftls_pkg::PH_INT;
            else if (is_point) next_phase = ftls_pkg::PH_POINT;
         end
         ftls_pkg::PH_INT: begin
            if (is_digit)      next_phase = ftls_pkg::PH_INT;
            else if (is_point) next_phase = ftls_pkg::PH_FRAC;
            else if (is_exp)   next_phase = ftls_pkg::PH_EXP_E;
         end
         ftls_pkg::PH_POINT: begin
            if (is_digit) next_phase = ftls_pkg::PH_FRAC;
         end
         ftls_pkg::PH_FRAC: begin
            if (is_digit)    next_phase = ftls_pkg::PH_FRAC;
            else if (is_exp) next_phase = ftls_pkg::PH_EXP_E;
         end
         ftls_pkg::PH_EXP_E: begin
            if (is_minus)      next_phase = ftls_pkg::PH_EXP_SIGN;
            else if (is_digit) next_phase = ftls_pkg::PH_EXP_DIG;
         end
         ftls_pkg::PH_EXP_SIGN, ftls_pkg::PH_EXP_DIG: begin
            if (is_digit) next_phase = ftls_pkg::PH_EXP_DIG;
         end
         default: begin
            next_phase = ftls_pkg::PH_DONE;
         end
      endcase

      result.phase     = next_phase;
      result.accepting = (next_phase == ftls_pkg::PH_INT)
                      || (next_phase == ftls_pkg::PH_FRAC)
                      || (next_phase == ftls_pkg::PH_EXP_DIG);
   end

endmodule

/* rtl/core/float_token_length_scanner_core.sv */
// channel | dir | word                                             | handshake
// req     | in  | char_code[7:0], is_final                         | valid / ready
// rsp     | out | token_valid, token_length[7:0], length_saturated | valid / ready
//
// one character word per cycle sustained unless a final word is stalled; a word is
// registered, stepped through the phase logic, and on is_final the result lands in
// the output register once that register is free
// the output register parts the sides: req keeps flowing while a result waits,
// only a final word stalls behind an untaken result
// synchronous active-high reset returns the scan state to start of string
module float_token_length_scanner_core #(
   parameter int unsigned MAX_LENGTH = 255
) (
   input  logic          clock,
   input  logic          reset,
   ftls_stream_if.sink   req,
   ftls_stream_if.source rsp
);

   localparam int unsigned COUNT_W = $clog2(MAX_LENGTH + 1);

   logic                              in_valid_ff, in_valid_in;
   logic [ftls_pkg::CHAR_W-1:0]       in_char_ff;
   logic                              in_final_ff;

   ftls_pkg::phase_type               phase_ff, phase_in;
   logic [COUNT_W-1:0]                count_ff, count_in;
   logic [COUNT_W-1:0]                acc_len_ff, acc_len_in;
   logic                              acc_flag_ff, acc_flag_in;
   logic                              sat_flag_ff, sat_flag_in;

   logic                              out_valid_ff, out_valid_in;
   ftls_pkg::rsp_word_type            out_word_ff, out_word_in;

   ftls_pkg::step_result_type         step;
   logic                              out_free;
   logic                              step_fire;
   logic                              req_take;
   logic                              at_limit;

   ftls_scan_step u_step (
      .phase     (phase_ff),
      .char_code (in_char_ff),
      .result    (step)
   );

   assign out_free  = !out_valid_ff || rsp.ready;
   assign step_fire = in_valid_ff && (!in_final_ff || out_free);
   assign req.ready = !in_valid_ff || step_fire;
   assign req_take  = req.valid && req.ready;
   assign at_limit  = (count_ff == COUNT_W'(MAX_LENGTH));

   assign rsp.valid   = out_valid_ff;
   assign rsp.payload = out_word_ff;

   always_comb begin
      in_valid_in  = req_take || (in_valid_ff && !step_fire);

      phase_in    = phase_ff;
      count_in    = count_ff;
      acc_len_in  = acc_len_ff;
      acc_flag_in = acc_flag_ff;
      sat_flag_in = sat_flag_ff;

      out_valid_in = out_valid_ff && !rsp.ready;
      out_word_in  = out_word_ff;

      if (step_fire) begin
         if (at_limit) begin
            sat_flag_in = 1'b1;
            phase_in    = ftls_pkg::PH_DONE;
         end else begin
            count_in = COUNT_W'(count_ff + 1'b1);
            phase_in = step.phase;
            if (step.accepting) begin
               acc_len_in  = count_in;
               acc_flag_in = 1'b1;
            end
         end

         if (in_final_ff) begin
            out_valid_in                 = 1'b1;
            out_word_in.token_valid      = acc_flag_in;
            out_word_in.token_length     = acc_flag_in
                                         ? ftls_pkg::LENGTH_W'(acc_len_in)
                                         : '0;
            out_word_in.length_saturated = sat_flag_in;
            phase_in    = ftls_pkg::PH_START;
            count_in    = '0;
            acc_len_in  = '0;
            acc_flag_in = 1'b0;
            sat_flag_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         phase_ff     <= ftls_pkg::PH_START;
         count_ff     <= '0;
         acc_len_ff   <= '0;
         acc_flag_ff  <= 1'b0;
         sat_flag_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         acc_len_ff   <= acc_len_in;
         acc_flag_ff  <= acc_flag_in;
         sat_flag_ff  <= sat_flag_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff  <= req.payload.char_code;
         in_final_ff <= req.payload.is_final;
      end
      out_word_ff <= out_word_in;
   end

endmodule

/* rtl/core/ftls_checker.sv */
module ftls_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input ftls_pkg::rsp_word_type        rsp_payload
);

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   a_ready_when_rsp_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req stalled with empty output register");

   a_no_token_no_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.token_valid) |-> (rsp_payload.token_length == '0))
      else $error("length without token");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled rsp word changed");

endmodule

bind float_token_length_scanner_core ftls_checker u_ftls_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req.valid),
   .req_ready   (req.ready),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_payload (rsp.payload)
);

/* tb/sv/float_token_length_scanner_checker.sv */
`timescale 1ns / 100ps
module float_token_length_scanner_checker #(
   parameter int unsigned MAX_LENGTH = 255
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  ftls_pkg::req_word_type req_word,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  ftls_pkg::rsp_word_type rsp_word,
   output int                     mismatch_count,
   output int                     pending_count
);

   localparam logic [ftls_pkg::CHAR_W-1:0] CH_ZERO = 8'h30;
   localparam logic [ftls_pkg::CHAR_W-1:0] CH_NINE = 8'h39;

   ftls_pkg::phase_type           scan_phase;
   int unsigned                   char_count;
   logic [ftls_pkg::LENGTH_W-1:0] best_length;
   logic                          best_flag;
   logic                          overflow_flag;
   ftls_pkg::rsp_word_type        token_q[$];

   initial mismatch_count = 0;

   function automatic ftls_pkg::phase_type advance_phase(ftls_pkg::phase_type ph,
                                                         logic [ftls_pkg::CHAR_W-1:0] code);
      logic digit;
      digit = (code >= CH_ZERO) && (code <= CH_NINE);
      case (ph)
         ftls_pkg::PH_START: begin
            if (code == ftls_pkg::CH_MINUS) return ftls_pkg::PH_SIGN;
            if (digit) return ftls_pkg::PH_INT;
            if (code == ftls_pkg::CH_POINT) return ftls_pkg::PH_POINT;
            return ftls_pkg::PH_DONE;
         end
         ftls_pkg::PH_SIGN: begin
            if (digit) return ftls_pkg::PH_INT;
            if (code == ftls_pkg::CH_POINT) return ftls_pkg::PH_POINT;
            return ftls_pkg::PH_DONE;
         end
         ftls_pkg::PH_INT: begin
            if (digit) return ftls_pkg::PH_INT;
            if (code == ftls_pkg::CH_POINT) return ftls_pkg::PH_FRAC;
            if (code == ftls_pkg::CH_EXP) return ftls_pkg::PH_EXP_E;
            return ftls_pkg::PH_DONE;
         end
         ftls_pkg::PH_POINT: begin
            if (digit) return ftls_pkg::PH_FRAC;
            return ftls_pkg::PH_DONE;
         end
         ftls_pkg::PH_FRAC: begin
            if (digit) return ftls_pkg::PH_FRAC;
            if (code == ftls_pkg::CH_EXP) return ftls_pkg::PH_EXP_E;
            return ftls_pkg::PH_DONE;
         end
         ftls_pkg::PH_EXP_E: begin
            if (code == ftls_pkg::CH_MINUS) return ftls_pkg::PH_EXP_SIGN;
            if (digit) return ftls_pkg::PH_EXP_DIG;
            return ftls_pkg::PH_DONE;
         end
         ftls_pkg::PH_EXP_SIGN, ftls_pkg::PH_EXP_DIG: begin
            if (digit) return ftls_pkg::PH_EXP_DIG;
            return ftls_pkg::PH_DONE;
         end
         default: return ftls_pkg::PH_DONE;
      endcase
   endfunction

   task automatic clear_scan();
      scan_phase    = ftls_pkg::PH_START;
      char_count    = 0;
      best_length   = '0;
      best_flag     = 1'b0;
      overflow_flag = 1'b0;
   endtask

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic scan_word(ftls_pkg::req_word_type word);
      ftls_pkg::rsp_word_type token;
      if (char_count >= MAX_LENGTH) begin
         overflow_flag = 1'b1;
         scan_phase    = ftls_pkg::PH_DONE;
      end else begin
         char_count++;
         scan_phase = advance_phase(scan_phase, word.char_code);
         if (scan_phase == ftls_pkg::PH_INT || scan_phase == ftls_pkg::PH_FRAC
             || scan_phase == ftls_pkg::PH_EXP_DIG) begin
            best_length = char_count[ftls_pkg::LENGTH_W-1:0];
            best_flag   = 1'b1;
         end
      end
      if (word.is_final) begin
         token.token_valid      = best_flag;
         token.token_length     = best_flag ? best_length : '0;
         token.length_saturated = overflow_flag;
         token_q.push_back(token);
         clear_scan();
      end
   endtask

   task automatic check_token(ftls_pkg::rsp_word_type got);
      ftls_pkg::rsp_word_type want;
      if (token_q.size() == 0) begin
         report_mismatch("result with none pending, token_length", got.token_length, 0);
      end else begin
         want = token_q.pop_front();
         if (got.token_valid !== want.token_valid)
            report_mismatch("token_valid", got.token_valid, want.token_valid);
         if (got.token_length !== want.token_length)
            report_mismatch("token_length", got.token_length, want.token_length);
         if (got.length_saturated !== want.length_saturated)
            report_mismatch("length_saturated", got.length_saturated, want.length_saturated);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_scan();
         token_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) check_token(rsp_word);
         if (req_valid && req_ready) scan_word(req_word);
      end
      pending_count <= token_q.size();
   end

endmodule

/* tb/sv/float_token_length_scanner_core_test.sv */
`timescale 1ns / 100ps
module float_token_length_scanner_core_test;

   localparam int unsigned MAX_LENGTH = 255;
   localparam logic [ftls_pkg::CHAR_W-1:0] CH_ZERO = 8'h30;

   logic        clock;
   logic        reset;
   logic        hold_go;
   int          sender_idle_pct;
   int          receiver_idle_pct;
   int          words_sent;
   int          mismatch_count;
   int          pending_count;
   int          hold_left;
   logic        hold_seen;
   byte unsigned text_q[$];

   ftls_stream_if #(.payload_type(ftls_pkg::req_word_type)) req_if ();
   ftls_stream_if #(.payload_type(ftls_pkg::rsp_word_type)) rsp_if ();

   float_token_length_scanner_core #(.MAX_LENGTH(MAX_LENGTH)) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   float_token_length_scanner_checker #(.MAX_LENGTH(MAX_LENGTH)) checker_0 (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_if.valid),
      .req_ready      (req_if.ready),
      .req_word       (req_if.payload),
      .rsp_valid      (rsp_if.valid),
      .rsp_ready      (rsp_if.ready),
      .rsp_word       (rsp_if.payload),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("FAILURE");
      $finish;
   end

   // receiver: random back-pressure plus one long hold
   initial begin
      rsp_if.ready <= 1'b0;
      hold_seen = 1'b0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_go && !hold_seen) begin
            hold_seen = 1'b1;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   task automatic send_char(input logic [ftls_pkg::CHAR_W-1:0] code, input logic last);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= '{char_code: code, is_final: last};
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      words_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
   endtask

   task automatic send_queue();
      foreach (text_q[i]) send_char(text_q[i], i == text_q.size() - 1);
   endtask

   task automatic push_digits(input int count);
      repeat (count) text_q.push_back(8'(CH_ZERO + $urandom_range(9)));
   endtask

   task automatic build_random_text();
      string alphabet;
      alphabet = "0123456789-.eE+ ";
      text_q.delete();
      case ($urandom_range(9))
         0, 1, 2, 3, 4, 5, 6: begin
            // mostly well formed numbers, sometimes cut short or with a tail
            if ($urandom_range(1)) text_q.push_back(ftls_pkg::CH_MINUS);
            push_digits($urandom_range(4));
            if ($urandom_range(2) == 0) begin
               text_q.push_back(ftls_pkg::CH_POINT);
               push_digits($urandom_range(3));
            end
            if ($urandom_range(2) == 0) begin
               text_q.push_back(ftls_pkg::CH_EXP);
               if ($urandom_range(2) == 0) text_q.push_back(ftls_pkg::CH_MINUS);
               push_digits($urandom_range(3));
            end
            repeat ($urandom_range(2)) text_q.push_back(8'($urandom_range(255)));
            if (text_q.size() == 0) push_digits(1);
         end
         7, 8: begin
            repeat ($urandom_range(8, 1)) text_q.push_back(8'($urandom_range(255)));
         end
         default: begin
            repeat ($urandom_range(10, 1))
               text_q.push_back(alphabet[$urandom_range(alphabet.len() - 1)]);
         end
      endcase
   endtask

   task automatic random_stretch(input int upto);
      while (words_sent < upto) begin
         build_random_text();
         send_queue();
      end
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      string directed_text[];
      directed_text = '{"-", ".", "-.", "7", "-.5", "3.", "1e", "2e-", "4e-9", "5.e1",
                        "x9", "E1"};
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      hold_go        <= 1'b0;
      sender_idle_pct   = 18;
      receiver_idle_pct = 52;
      words_sent        = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_text[i]) send_text(directed_text[i]);
      random_stretch(150);
      hold_go <= 1'b1;
      random_stretch(450);
      drain();

      sender_idle_pct   = 52;
      receiver_idle_pct = 18;
      // exactly the counter limit, no saturation
      text_q.delete();
      push_digits(MAX_LENGTH);
      send_queue();
      random_stretch(900);
      drain();

      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      // two words past the limit with an exponent near the end
      text_q.delete();
      text_q.push_back(ftls_pkg::CH_MINUS);
      push_digits(250);
      text_q.push_back(ftls_pkg::CH_EXP);
      text_q.push_back(ftls_pkg::CH_MINUS);
      push_digits(2);
      text_q.push_back(CH_ZERO);
      text_q.push_back(ftls_pkg::CH_EXP);
      send_queue();
      random_stretch(1400);
      drain();

      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
